/* design/trace_return_shadow_stack_core_assert.svh */
// Assertion macros for the shadow return stack checker.
`ifndef TRACE_RETURN_SHADOW_STACK_CORE_ASSERT_SVH
`define TRACE_RETURN_SHADOW_STACK_CORE_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define TSS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSS_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/tss_pkg.sv */
// Shared types, codes and constants for the shadow return stack.
`timescale 1ns / 1ps

package tss_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int ADDR_W              = 64;
   localparam int SLOT_W              = 3;
   localparam int FRAMES_W            = 6;
   localparam int CSR_INDEX_W         = 4;
   localparam int NUM_SLOTS           = 7;

   typedef enum logic [1:0] {
      OP_CALL   = 2'd0,
      OP_RETURN = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_RET_TRAMP   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CORE_OFFSET = CSR_INDEX_W'(1);

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   entry_addr;
      logic [ADDR_W-1:0]   parent_addr;
      logic [SLOT_W-1:0]   offset_slot;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   return_addr;
      logic [ADDR_W-1:0]   traced_func;
      status_type          status;
      logic [FRAMES_W-1:0] frames_held;
   } rsp_payload_type;

endpackage

/* design/tss_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
`timescale 1ns / 1ps

interface tss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/trace_return_shadow_stack_core.sv */
// Shadow return address stack for function tracing, top level.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  req_if  | in  | valid/ready         | operation, entry_addr, parent_addr, offset_slot
//  rsp_if  | out | valid/ready         | return_addr, traced_func, status, frames_held
//  csr_*   | in  | csr_we, no wait     | csr_index, csr_wdata
//
// One item per cycle while rsp_if is ready; each result passes stage 1 and the output register.
// The stack pointer and the frame memory are updated at the request transfer, so
// a pop may follow a push in the next cycle; memory read data is registered.
// A stalled response holds in the output register while one more item waits in stage 1.
// Reset empties the stack, clears CSRs and valid flags; frame memory is not cleared.
`timescale 1ns / 1ps

module trace_return_shadow_stack_core #(
   parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tss_stream_if.sink                      req_if,
   tss_stream_if.source                    rsp_if,
   input  logic                            csr_we,
   input  logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tss_pkg::ADDR_W-1:0]      csr_wdata
);
   import tss_pkg::*;

   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W   = $clog2(STACK_DEPTH);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(STACK_DEPTH);

   // configuration
   logic [ADDR_W-1:0] ret_tramp_ff;
   logic [ADDR_W-1:0] slot_offset_ff [NUM_SLOTS];

   // stack state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  saved_func_mem   [STACK_DEPTH];
   logic [ADDR_W-1:0]  saved_return_mem [STACK_DEPTH];
   logic [ADDR_W-1:0]  rd_func_ff, rd_ret_ff;

   // stage 1
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_from_mem_ff, s1_from_mem_in;
   status_type          s1_status_ff, s1_status_in;
   logic [ADDR_W-1:0]   s1_ret_ff, s1_ret_in;
   logic [ADDR_W-1:0]   s1_func_ff, s1_func_in;
   logic [FRAMES_W-1:0] s1_frames_ff;

   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_payload_ff;

   logic               req_accept, s1_advance;
   logic               is_full, is_empty, push_we, pop_re;
   logic [COUNT_W-1:0] count_dec;
   logic [PTR_W-1:0]   push_ptr, pop_ptr;
   logic [ADDR_W-1:0]  offset_sel, func_sum;

   assign s1_advance   = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_payload_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ret_tramp_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_offset_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_RET_TRAMP) begin
            ret_tramp_ff <= csr_wdata;
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (csr_index == CSR_CORE_OFFSET + CSR_INDEX_W'(i)) begin
               slot_offset_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // address translation
   always_comb begin
      offset_sel = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (req_if.payload.offset_slot == SLOT_W'(i)) begin
            offset_sel = slot_offset_ff[i];
         end
      end
      func_sum = req_if.payload.entry_addr + offset_sel;
   end

   assign is_full   = (count_ff == COUNT_MAX);
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - COUNT_W'(1);
   assign push_ptr  = count_ff[PTR_W-1:0];
   assign pop_ptr   = count_dec[PTR_W-1:0];

   always_comb begin
      push_we        = 1'b0;
      pop_re         = 1'b0;
      count_in       = count_ff;
      s1_from_mem_in = 1'b0;
      s1_status_in   = ST_OK;
      s1_ret_in      = '0;
      s1_func_in     = '0;
      unique case (req_if.payload.operation)
         OP_CALL: begin
            s1_func_in = func_sum;
            if (is_full) begin
               s1_status_in = ST_FULL;
               s1_ret_in    = req_if.payload.parent_addr;
            end else begin
               push_we   = req_accept;
               count_in  = count_ff + COUNT_W'(1);
               s1_ret_in = ret_tramp_ff;
            end
         end
         OP_RETURN: begin
            if (is_empty) begin
               s1_status_in = ST_EMPTY;
            end else begin
               pop_re         = req_accept;
               count_in       = count_dec;
               s1_from_mem_in = 1'b1;
            end
         end
         OP_FLUSH: begin
            count_in = '0;
         end
         OP_IGNORE: begin
         end
         default: begin
         end
      endcase
   end

   // stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept) begin
         count_ff <= count_in;
      end
   end

   // frame memory, registered read
   always_ff @(posedge clock) begin
      if (push_we) begin
         saved_func_mem[push_ptr]   <= func_sum;
         saved_return_mem[push_ptr] <= req_if.payload.parent_addr;
      end
      if (pop_re) begin
         rd_func_ff <= saved_func_mem[pop_ptr];
         rd_ret_ff  <= saved_return_mem[pop_ptr];
      end
   end

   // stage 1
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_from_mem_ff <= s1_from_mem_in;
         s1_status_ff   <= s1_status_in;
         s1_ret_ff      <= s1_ret_in;
         s1_func_ff     <= s1_func_in;
         s1_frames_ff   <= FRAMES_W'(count_in);
      end
   end

   // output register
   assign out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_payload_ff.return_addr <= s1_from_mem_ff ? rd_ret_ff : s1_ret_ff;
         out_payload_ff.traced_func <= s1_from_mem_ff ? rd_func_ff : s1_func_ff;
         out_payload_ff.status      <= s1_status_ff;
         out_payload_ff.frames_held <= s1_frames_ff;
      end
   end

endmodule

/* design/tss_checker.sv */
// Port-level checker for the shadow return stack, bound to the top level.
`timescale 1ns / 1ps
`include "trace_return_shadow_stack_core_assert.svh"

module tss_checker #(
   parameter int STACK_DEPTH = tss_pkg::STACK_DEPTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tss_pkg::rsp_payload_type rsp_payload
);
   import tss_pkg::*;

   localparam logic [FRAMES_W-1:0] FULL_FRAMES = FRAMES_W'(STACK_DEPTH);

   `TSS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `TSS_ASSERT(a_full_frames, rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.frames_held == FULL_FRAMES, "full status without a full stack")
   `TSS_ASSERT(a_empty_zero, rsp_valid && rsp_payload.status == ST_EMPTY |-> rsp_payload.frames_held == '0 && rsp_payload.return_addr == '0 && rsp_payload.traced_func == '0, "empty pop with nonzero fields")
   `TSS_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind trace_return_shadow_stack_core tss_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_tss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
